// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// assumes clk and rst_n are visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ACEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ACEU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/acceu_pkg.sv
// shared types, opcodes and widths of the accumulator execute unit
// no dependencies
`default_nettype none

package acceu_pkg;

    localparam int DATA_W = 8;
    localparam int OP_W = 6;
    localparam int ADDR_W = 12;
    localparam int WIDE_W = 16;
    localparam int MEM_ADDR_BITS_DEF = 12;
    localparam int IO_ADDR_BITS_DEF = 8;

    localparam logic [DATA_W-1:0] SIGN_MASK = 8'h80;

    localparam logic [OP_W-1:0] OP_ADD  = 6'h3C;
    localparam logic [OP_W-1:0] OP_SUB  = 6'h3A;
    localparam logic [OP_W-1:0] OP_MUL  = 6'h36;
    localparam logic [OP_W-1:0] OP_AND  = 6'h34;
    localparam logic [OP_W-1:0] OP_OR   = 6'h32;
    localparam logic [OP_W-1:0] OP_NOT  = 6'h30;
    localparam logic [OP_W-1:0] OP_XOR  = 6'h2E;
    localparam logic [OP_W-1:0] OP_SHL  = 6'h2C;
    localparam logic [OP_W-1:0] OP_SHR  = 6'h2A;
    localparam logic [OP_W-1:0] OP_WM   = 6'h02;
    localparam logic [OP_W-1:0] OP_RM   = 6'h04;
    localparam logic [OP_W-1:0] OP_RIO  = 6'h08;
    localparam logic [OP_W-1:0] OP_WIO  = 6'h0A;
    localparam logic [OP_W-1:0] OP_WB   = 6'h0C;
    localparam logic [OP_W-1:0] OP_WIB  = 6'h0E;
    localparam logic [OP_W-1:0] OP_WACC = 6'h12;
    localparam logic [OP_W-1:0] OP_RACC = 6'h16;
    localparam logic [OP_W-1:0] OP_SWAP = 6'h1C;
    localparam logic [OP_W-1:0] OP_BR   = 6'h06;
    localparam logic [OP_W-1:0] OP_BRE  = 6'h28;
    localparam logic [OP_W-1:0] OP_BRNE = 6'h26;
    localparam logic [OP_W-1:0] OP_BRGT = 6'h24;
    localparam logic [OP_W-1:0] OP_BRLT = 6'h22;

    typedef struct packed {
        logic o;
        logic s;
        logic c;
        logic z;
    } flags_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] acc;
        flags_t            flags;
    } alu_res_t;

    typedef struct packed {
        logic main_we;
        logic io_we;
    } store_we_t;

endpackage

`default_nettype wire

// File: rtl/acceu_alu.sv
// combinational alu: accumulator with mbr, flags from the wide result
// depends on acceu_pkg
`default_nettype none

module acceu_alu
(
    input  wire logic [acceu_pkg::OP_W-1:0]   func,
    input  wire logic [acceu_pkg::DATA_W-1:0] acc,
    input  wire logic [acceu_pkg::DATA_W-1:0] mbr,
    output acceu_pkg::alu_res_t               res
);

    logic [acceu_pkg::WIDE_W-1:0] wide;
    logic                         neg;
    logic                         hit;
    logic                         carry;

    always_comb
    begin
        wide = '0;
        neg  = 1'b0;
        hit  = 1'b1;
        unique case (func)
            acceu_pkg::OP_ADD:  wide = {8'd0, acc} + {8'd0, mbr};
            acceu_pkg::OP_SUB:  wide = {8'd0, acc} + {8'd0, 8'(~mbr + 8'd1)};
            acceu_pkg::OP_MUL:  wide = {8'd0, acc} * {8'd0, mbr};
            acceu_pkg::OP_AND:  wide = {8'd0, acc & mbr};
            acceu_pkg::OP_OR:   wide = {8'd0, acc | mbr};
            acceu_pkg::OP_XOR:  wide = {8'd0, acc ^ mbr};
            acceu_pkg::OP_NOT:
            begin
                wide = {8'hFF, ~acc};
                neg  = 1'b1;
            end
            acceu_pkg::OP_SHL:  wide = {7'd0, acc, 1'b0};
            acceu_pkg::OP_SHR:  wide = {9'd0, acc[7:1]};
            acceu_pkg::OP_WACC: wide = {8'd0, mbr};
            acceu_pkg::OP_RACC: wide = {8'd0, acc};
            default:            hit  = 1'b0;
        endcase
    end

    assign carry = !neg && (|wide[15:8]);

    assign res.hit     = hit;
    assign res.acc     = wide[7:0];
    assign res.flags.z = (wide[7:0] == 8'd0);
    assign res.flags.c = carry;
    assign res.flags.s = |(wide[7:0] & acceu_pkg::SIGN_MASK);
    assign res.flags.o = carry || neg;

endmodule

`default_nettype wire

// File: rtl/acceu_stores.sv
// main and i/o stores, read when an item is taken in, written when it executes
// depends on acceu_pkg
`default_nettype none

module acceu_stores
#(
    parameter int MEM_ADDR_BITS = acceu_pkg::MEM_ADDR_BITS_DEF,
    parameter int IO_ADDR_BITS  = acceu_pkg::IO_ADDR_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rd_en,
    input  wire logic [acceu_pkg::ADDR_W-1:0]    rd_addr,
    input  wire acceu_pkg::store_we_t            wr,
    input  wire logic [acceu_pkg::ADDR_W-1:0]    wr_addr,
    input  wire logic [acceu_pkg::DATA_W-1:0]    main_wdata,
    input  wire logic [acceu_pkg::DATA_W-1:0]    io_wdata,
    output logic      [acceu_pkg::DATA_W-1:0]    main_rdata,
    output logic      [acceu_pkg::DATA_W-1:0]    io_rdata
);

    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
    localparam int IO_DEPTH  = 1 << IO_ADDR_BITS;

    logic [acceu_pkg::DATA_W-1:0] main_mem [MEM_DEPTH];
    logic [acceu_pkg::DATA_W-1:0] io_mem [IO_DEPTH];

    logic [MEM_ADDR_BITS-1:0] main_ra;
    logic [MEM_ADDR_BITS-1:0] main_wa;
    logic [IO_ADDR_BITS-1:0]  io_ra;
    logic [IO_ADDR_BITS-1:0]  io_wa;

    logic [acceu_pkg::DATA_W-1:0] main_rd_reg;
    logic [acceu_pkg::DATA_W-1:0] io_rd_reg;
    logic [acceu_pkg::DATA_W-1:0] main_fwd_data_reg;
    logic [acceu_pkg::DATA_W-1:0] io_fwd_data_reg;
    logic                         main_fwd_reg;
    logic                         io_fwd_reg;

    assign main_ra = MEM_ADDR_BITS'(rd_addr);
    assign main_wa = MEM_ADDR_BITS'(wr_addr);
    assign io_ra   = IO_ADDR_BITS'(rd_addr);
    assign io_wa   = IO_ADDR_BITS'(wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr.main_we)
        begin
            main_mem[main_wa] <= main_wdata;
        end
        if (rd_en)
        begin
            main_rd_reg <= main_mem[main_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.io_we)
        begin
            io_mem[io_wa] <= io_wdata;
        end
        if (rd_en)
        begin
            io_rd_reg <= io_mem[io_ra];
        end
    end

    // write in the same edge as the read: pass the new byte on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_fwd_reg <= 1'b0;
            io_fwd_reg   <= 1'b0;
        end
        else if (rd_en)
        begin
            main_fwd_reg <= wr.main_we && (main_wa == main_ra);
            io_fwd_reg   <= wr.io_we && (io_wa == io_ra);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            main_fwd_data_reg <= main_wdata;
            io_fwd_data_reg   <= io_wdata;
        end
    end

    assign main_rdata = main_fwd_reg ? main_fwd_data_reg : main_rd_reg;
    assign io_rdata   = io_fwd_reg ? io_fwd_data_reg : io_rd_reg;

endmodule

`default_nettype wire

// File: rtl/accumulator_cpu_execute_unit.sv
// execute unit: one instruction per cycle while the result side does not stall;
// an accepted item passes the input register, then the architectural registers,
// which also hold the result; the store read is issued at accept, ahead of execute
// asynchronous active-low reset clears registers, flags, pc and valids; stores stay
// depends on acceu_pkg, acceu_alu, acceu_stores
`default_nettype none

module accumulator_cpu_execute_unit
#(
    parameter int MEM_ADDR_BITS = acceu_pkg::MEM_ADDR_BITS_DEF,
    parameter int IO_ADDR_BITS  = acceu_pkg::IO_ADDR_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [acceu_pkg::OP_W-1:0]   func,
    input  wire logic [acceu_pkg::ADDR_W-1:0] address,
    input  wire logic [acceu_pkg::DATA_W-1:0] immediate,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [acceu_pkg::DATA_W-1:0] acc_value,
    output logic      [acceu_pkg::DATA_W-1:0] mbr_value,
    output logic      [acceu_pkg::DATA_W-1:0] iobr_value,
    output logic                              zero_flag,
    output logic                              carry_flag,
    output logic                              sign_flag,
    output logic                              overflow_flag,
    output logic                              branch_taken,
    output logic      [acceu_pkg::ADDR_W-1:0] pc_value
);

    logic                         s1_valid_reg;
    logic [acceu_pkg::OP_W-1:0]   s1_func_reg;
    logic [acceu_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [acceu_pkg::DATA_W-1:0] s1_imm_reg;

    logic [acceu_pkg::DATA_W-1:0] acc_reg;
    logic [acceu_pkg::DATA_W-1:0] acc_next;
    logic [acceu_pkg::DATA_W-1:0] mbr_reg;
    logic [acceu_pkg::DATA_W-1:0] mbr_next;
    logic [acceu_pkg::DATA_W-1:0] iobr_reg;
    logic [acceu_pkg::DATA_W-1:0] iobr_next;
    acceu_pkg::flags_t            flags_reg;
    acceu_pkg::flags_t            flags_next;
    logic [acceu_pkg::ADDR_W-1:0] pc_reg;
    logic [acceu_pkg::ADDR_W-1:0] pc_next;
    logic                         taken_reg;
    logic                         taken_next;
    logic                         out_valid_reg;

    logic                         accept;
    logic                         advance;
    acceu_pkg::alu_res_t          alu_res;
    acceu_pkg::store_we_t         store_we;
    logic [acceu_pkg::DATA_W-1:0] main_rdata;
    logic [acceu_pkg::DATA_W-1:0] io_rdata;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_addr_reg <= address;
            s1_imm_reg  <= immediate;
        end
    end

    acceu_alu u_alu
    (
        .func (s1_func_reg),
        .acc  (acc_reg),
        .mbr  (mbr_reg),
        .res  (alu_res)
    );

    acceu_stores
    #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .IO_ADDR_BITS  (IO_ADDR_BITS)
    )
    u_stores
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (address),
        .wr         (store_we),
        .wr_addr    (s1_addr_reg),
        .main_wdata (mbr_reg),
        .io_wdata   (iobr_reg),
        .main_rdata (main_rdata),
        .io_rdata   (io_rdata)
    );

    always_comb
    begin
        acc_next         = acc_reg;
        mbr_next         = mbr_reg;
        iobr_next        = iobr_reg;
        flags_next       = flags_reg;
        pc_next          = pc_reg;
        taken_next       = 1'b0;
        store_we.main_we = 1'b0;
        store_we.io_we   = 1'b0;
        if (alu_res.hit)
        begin
            acc_next   = alu_res.acc;
            flags_next = alu_res.flags;
            if (s1_func_reg == acceu_pkg::OP_RACC)
            begin
                mbr_next = acc_reg;
            end
        end
        else
        begin
            unique case (s1_func_reg)
                acceu_pkg::OP_WM:   store_we.main_we = advance;
                acceu_pkg::OP_RM:   mbr_next = main_rdata;
                acceu_pkg::OP_WIO:  store_we.io_we = advance;
                acceu_pkg::OP_RIO:  iobr_next = io_rdata;
                acceu_pkg::OP_WB:   mbr_next = s1_imm_reg;
                acceu_pkg::OP_WIB:  iobr_next = s1_imm_reg;
                acceu_pkg::OP_SWAP:
                begin
                    mbr_next  = iobr_reg;
                    iobr_next = mbr_reg;
                end
                acceu_pkg::OP_BR:   taken_next = 1'b1;
                acceu_pkg::OP_BRE:  taken_next = flags_reg.z;
                acceu_pkg::OP_BRNE: taken_next = !flags_reg.z;
                acceu_pkg::OP_BRGT: taken_next = !flags_reg.z && !flags_reg.s;
                acceu_pkg::OP_BRLT: taken_next = flags_reg.s;
                default:            taken_next = 1'b0;
            endcase
            if (taken_next)
            begin
                pc_next = s1_addr_reg;
            end
        end
    end

    // architectural registers double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            mbr_reg       <= '0;
            iobr_reg      <= '0;
            flags_reg     <= '0;
            pc_reg        <= '0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg   <= acc_next;
                mbr_reg   <= mbr_next;
                iobr_reg  <= iobr_next;
                flags_reg <= flags_next;
                pc_reg    <= pc_next;
                taken_reg <= taken_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign acc_value     = acc_reg;
    assign mbr_value     = mbr_reg;
    assign iobr_value    = iobr_reg;
    assign zero_flag     = flags_reg.z;
    assign carry_flag    = flags_reg.c;
    assign sign_flag     = flags_reg.s;
    assign overflow_flag = flags_reg.o;
    assign branch_taken  = taken_reg;
    assign pc_value      = pc_reg;

endmodule

`default_nettype wire

// File: rtl/acceu_checker.sv
// port-level checks on the execute unit, bound to the top level
// depends on assert_macros.svh and accumulator_cpu_execute_unit
`default_nettype none

`include "assert_macros.svh"

module acceu_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] acc_value,
    input wire logic       carry_flag,
    input wire logic       overflow_flag,
    input wire logic [11:0] pc_value
);

    `ACEU_ASSERT_ALWAYS(a_no_result_out_of_reset, $rose(rst_n) |-> !out_valid, "result valid at reset release")

    `ACEU_ASSERT(a_out_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    `ACEU_ASSERT(a_out_payload_holds, out_valid && !out_ready |=> $stable(acc_value) && $stable(pc_value), "result changed while stalled")

    `ACEU_ASSERT(a_carry_sets_overflow, out_valid |-> !carry_flag || overflow_flag, "carry without overflow")

    `ACEU_ASSERT(a_full_blocks_input, out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready, "item taken with no room")

endmodule

bind accumulator_cpu_execute_unit acceu_checker u_acceu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .acc_value     (acc_value),
    .carry_flag    (carry_flag),
    .overflow_flag (overflow_flag),
    .pc_value      (pc_value)
);

`default_nettype wire

// File: test/tb_accumulator_cpu_execute_unit.sv
// testbench for accumulator_cpu_execute_unit: directed and random instruction streams,
// each result checked against a cycle-free model of the accumulator machine
// depends on acceu_pkg and the execute unit rtl
`timescale 1ns / 1ps

module tb_accumulator_cpu_execute_unit;

    localparam logic [acceu_pkg::OP_W-1:0] OP_END        = 6'h3E;
    localparam logic [acceu_pkg::OP_W-1:0] OP_UNUSED_MIN = 6'h00;
    localparam logic [acceu_pkg::OP_W-1:0] OP_UNUSED_MAX = 6'h3F;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RX_HOLD_LEN   = 400;
    localparam int MAIN_DEPTH    = 1 << acceu_pkg::MEM_ADDR_BITS_DEF;
    localparam int IO_DEPTH      = 1 << acceu_pkg::IO_ADDR_BITS_DEF;

    typedef struct packed {
        logic [acceu_pkg::DATA_W-1:0] acc;
        logic [acceu_pkg::DATA_W-1:0] mbr;
        logic [acceu_pkg::DATA_W-1:0] iobr;
        logic                         z;
        logic                         c;
        logic                         s;
        logic                         o;
        logic                         taken;
        logic [acceu_pkg::ADDR_W-1:0] pc;
    } machine_view_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [acceu_pkg::OP_W-1:0]   func = '0;
    logic [acceu_pkg::ADDR_W-1:0] address = '0;
    logic [acceu_pkg::DATA_W-1:0] immediate = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [acceu_pkg::DATA_W-1:0] acc_value;
    logic [acceu_pkg::DATA_W-1:0] mbr_value;
    logic [acceu_pkg::DATA_W-1:0] iobr_value;
    logic                         zero_flag;
    logic                         carry_flag;
    logic                         sign_flag;
    logic                         overflow_flag;
    logic                         branch_taken;
    logic [acceu_pkg::ADDR_W-1:0] pc_value;

    // model state
    logic [acceu_pkg::DATA_W-1:0] acc_q = '0;
    logic [acceu_pkg::DATA_W-1:0] mbr_q = '0;
    logic [acceu_pkg::DATA_W-1:0] iobr_q = '0;
    acceu_pkg::flags_t            flags_q = '0;
    logic [acceu_pkg::ADDR_W-1:0] pc_q = '0;
    logic [acceu_pkg::DATA_W-1:0] main_mem [MAIN_DEPTH];
    logic [acceu_pkg::DATA_W-1:0] io_mem [IO_DEPTH];
    bit                           main_written [MAIN_DEPTH];
    bit                           io_written [IO_DEPTH];
    int                           main_written_list [$];
    int                           io_written_list [$];

    machine_view_t     expected_views_q [$];

    int                error_count = 0;
    int                instr_count = 0;
    int                results_checked = 0;
    int                branches_taken = 0;
    int                cycle_count = 0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    logic              rx_holding = 1'b0;
    event              rx_hold_go;

    accumulator_cpu_execute_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .address       (address),
        .immediate     (immediate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .acc_value     (acc_value),
        .mbr_value     (mbr_value),
        .iobr_value    (iobr_value),
        .zero_flag     (zero_flag),
        .carry_flag    (carry_flag),
        .sign_flag     (sign_flag),
        .overflow_flag (overflow_flag),
        .branch_taken  (branch_taken),
        .pc_value      (pc_value)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_checked, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic execute_instruction(input logic [acceu_pkg::OP_W-1:0] op,
                                       input logic [acceu_pkg::ADDR_W-1:0] addr,
                                       input logic [acceu_pkg::DATA_W-1:0] imm);
        logic [31:0]                  r;
        logic [acceu_pkg::DATA_W-1:0] twos;
        logic [acceu_pkg::DATA_W-1:0] t;
        logic                         neg;
        logic                         alu;
        logic                         take;
        logic                         carry;
        machine_view_t                view;
        r = '0;
        neg = 1'b0;
        alu = 1'b1;
        take = 1'b0;
        twos = ~mbr_q + 8'd1;
        case (op)
            acceu_pkg::OP_ADD:  r = {24'b0, acc_q} + {24'b0, mbr_q};
            acceu_pkg::OP_SUB:  r = {24'b0, acc_q} + {24'b0, twos};
            acceu_pkg::OP_MUL:  r = {24'b0, acc_q} * {24'b0, mbr_q};
            acceu_pkg::OP_AND:  r = {24'b0, acc_q & mbr_q};
            acceu_pkg::OP_OR:   r = {24'b0, acc_q | mbr_q};
            acceu_pkg::OP_XOR:  r = {24'b0, acc_q ^ mbr_q};
            acceu_pkg::OP_NOT:
            begin
                r = ~{24'b0, acc_q};
                neg = 1'b1;
            end
            acceu_pkg::OP_SHL:  r = {24'b0, acc_q} << 1;
            acceu_pkg::OP_SHR:  r = {24'b0, acc_q} >> 1;
            acceu_pkg::OP_WACC: r = {24'b0, mbr_q};
            acceu_pkg::OP_RACC:
            begin
                r = {24'b0, acc_q};
                mbr_q = acc_q;
            end
            default: alu = 1'b0;
        endcase
        if (alu)
        begin
            acc_q = r[7:0];
            carry = !neg && (r > 32'd255);
            flags_q.z = (r[7:0] == 8'd0);
            flags_q.c = carry;
            flags_q.s = r[7];
            flags_q.o = carry || neg;
        end
        else
        begin
            case (op)
                acceu_pkg::OP_WM:
                begin
                    main_mem[addr] = mbr_q;
                    if (!main_written[addr])
                        main_written_list.push_back(int'(addr));
                    main_written[addr] = 1'b1;
                end
                acceu_pkg::OP_RM:  mbr_q = main_mem[addr];
                acceu_pkg::OP_WIO:
                begin
                    io_mem[addr[7:0]] = iobr_q;
                    if (!io_written[addr[7:0]])
                        io_written_list.push_back(int'(addr[7:0]));
                    io_written[addr[7:0]] = 1'b1;
                end
                acceu_pkg::OP_RIO: iobr_q = io_mem[addr[7:0]];
                acceu_pkg::OP_WB:  mbr_q = imm;
                acceu_pkg::OP_WIB: iobr_q = imm;
                acceu_pkg::OP_SWAP:
                begin
                    t = mbr_q;
                    mbr_q = iobr_q;
                    iobr_q = t;
                end
                acceu_pkg::OP_BR:   take = 1'b1;
                acceu_pkg::OP_BRE:  take = flags_q.z;
                acceu_pkg::OP_BRNE: take = !flags_q.z;
                acceu_pkg::OP_BRGT: take = !flags_q.z && !flags_q.s;
                acceu_pkg::OP_BRLT: take = flags_q.s;
                default: ;
            endcase
            if (take)
            begin
                pc_q = addr;
                branches_taken++;
            end
        end
        view.acc = acc_q;
        view.mbr = mbr_q;
        view.iobr = iobr_q;
        view.z = flags_q.z;
        view.c = flags_q.c;
        view.s = flags_q.s;
        view.o = flags_q.o;
        view.taken = take;
        view.pc = pc_q;
        expected_views_q.push_back(view);
    endtask

    task automatic send_item(input logic [acceu_pkg::OP_W-1:0] op,
                             input logic [acceu_pkg::ADDR_W-1:0] addr,
                             input logic [acceu_pkg::DATA_W-1:0] imm);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        address <= addr;
        immediate <= imm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        execute_instruction(op, addr, imm);
        instr_count++;
    endtask

    // result side: check, then pick the next ready level
    always @(posedge clk)
    begin
        machine_view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_views_q.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_views_q.pop_front();
                check_field("acc_value", acc_value, want.acc);
                check_field("mbr_value", mbr_value, want.mbr);
                check_field("iobr_value", iobr_value, want.iobr);
                check_field("zero_flag", zero_flag, want.z);
                check_field("carry_flag", carry_flag, want.c);
                check_field("sign_flag", sign_flag, want.s);
                check_field("overflow_flag", overflow_flag, want.o);
                check_field("branch_taken", branch_taken, want.taken);
                check_field("pc_value", pc_value, want.pc);
            end
            results_checked++;
        end
        out_ready <= !rx_holding && ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        forever
        begin
            @(rx_hold_go);
            rx_holding <= 1'b1;
            repeat (RX_HOLD_LEN) @(posedge clk);
            rx_holding <= 1'b0;
        end
    end

    function automatic logic [acceu_pkg::DATA_W-1:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [acceu_pkg::ADDR_W-1:0] rand_address();
        case ($urandom_range(15))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [acceu_pkg::OP_W-1:0] pick_unknown_op();
        logic [acceu_pkg::OP_W-1:0] op;
        do
            op = 6'($urandom_range(63));
        while (op inside {acceu_pkg::OP_ADD, acceu_pkg::OP_SUB, acceu_pkg::OP_MUL,
                          acceu_pkg::OP_AND, acceu_pkg::OP_OR, acceu_pkg::OP_NOT,
                          acceu_pkg::OP_XOR, acceu_pkg::OP_SHL, acceu_pkg::OP_SHR,
                          acceu_pkg::OP_WM, acceu_pkg::OP_RM, acceu_pkg::OP_RIO,
                          acceu_pkg::OP_WIO, acceu_pkg::OP_WB, acceu_pkg::OP_WIB,
                          acceu_pkg::OP_WACC, acceu_pkg::OP_RACC, acceu_pkg::OP_SWAP,
                          acceu_pkg::OP_BR, acceu_pkg::OP_BRE, acceu_pkg::OP_BRNE,
                          acceu_pkg::OP_BRGT, acceu_pkg::OP_BRLT});
        return op;
    endfunction

    task automatic send_random_instruction();
        int unsigned                  pick;
        logic [acceu_pkg::OP_W-1:0]   op;
        logic [acceu_pkg::ADDR_W-1:0] addr;
        logic [acceu_pkg::DATA_W-1:0] imm;
        pick = $urandom_range(99);
        addr = rand_address();
        imm = rand_byte();
        if (pick < 40)
        begin
            case ($urandom_range(10))
                0: op = acceu_pkg::OP_ADD;
                1: op = acceu_pkg::OP_SUB;
                2: op = acceu_pkg::OP_MUL;
                3: op = acceu_pkg::OP_AND;
                4: op = acceu_pkg::OP_OR;
                5: op = acceu_pkg::OP_XOR;
                6: op = acceu_pkg::OP_NOT;
                7: op = acceu_pkg::OP_SHL;
                8: op = acceu_pkg::OP_SHR;
                9: op = acceu_pkg::OP_WACC;
                default: op = acceu_pkg::OP_RACC;
            endcase
        end
        else if (pick < 55)
            op = $urandom_range(1) ? acceu_pkg::OP_WB : acceu_pkg::OP_WIB;
        else if (pick < 80)
        begin
            case ($urandom_range(4))
                0: op = acceu_pkg::OP_WM;
                1: op = acceu_pkg::OP_RM;
                2: op = acceu_pkg::OP_WIO;
                3: op = acceu_pkg::OP_RIO;
                default: op = acceu_pkg::OP_SWAP;
            endcase
        end
        else if (pick < 95)
        begin
            case ($urandom_range(4))
                0: op = acceu_pkg::OP_BR;
                1: op = acceu_pkg::OP_BRE;
                2: op = acceu_pkg::OP_BRNE;
                3: op = acceu_pkg::OP_BRGT;
                default: op = acceu_pkg::OP_BRLT;
            endcase
        end
        else
            op = pick_unknown_op();
        // reads only touch entries already written
        if (op == acceu_pkg::OP_RM)
        begin
            if (main_written_list.size() == 0)
                op = acceu_pkg::OP_WM;
            else
                addr = 12'(main_written_list[$urandom_range(main_written_list.size() - 1)]);
        end
        if (op == acceu_pkg::OP_RIO)
        begin
            if (io_written_list.size() == 0)
                op = acceu_pkg::OP_WIO;
            else
                addr = {4'($urandom_range(15)),
                        8'(io_written_list[$urandom_range(io_written_list.size() - 1)])};
        end
        send_item(op, addr, imm);
    endtask

    task automatic test_alu_extremes();
        send_item(acceu_pkg::OP_WB, 12'h000, 8'hFF);
        send_item(acceu_pkg::OP_WACC, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_NOT, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_ADD, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_SUB, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_MUL, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_AND, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_OR, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_XOR, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_SHL, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_SHR, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_RACC, 12'h000, 8'h00);
    endtask

    task automatic test_moves_and_stores();
        send_item(acceu_pkg::OP_WM, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_RM, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_WIB, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_WIO, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_RIO, 12'h0FF, 8'h00);
        send_item(acceu_pkg::OP_SWAP, 12'h000, 8'h00);
    endtask

    task automatic test_branches();
        send_item(acceu_pkg::OP_BRE, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_BRNE, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_BRGT, 12'hFFF, 8'h00);
        send_item(acceu_pkg::OP_BRLT, 12'h000, 8'h00);
        send_item(acceu_pkg::OP_BR, 12'hFFF, 8'h00);
    endtask

    task automatic test_unknown_opcodes();
        send_item(OP_END, 12'h5A5, 8'hFF);
        send_item(OP_UNUSED_MAX, 12'hFFF, 8'hFF);
        send_item(OP_UNUSED_MIN, 12'h000, 8'h00);
    endtask

    task automatic test_random_mix(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input int n);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_random_instruction();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        -> rx_hold_go;
        repeat (40) send_random_instruction();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alu_extremes();
        test_moves_and_stores();
        test_branches();
        test_unknown_opcodes();
        test_random_mix(36, 52, 590);
        test_output_backpressure();
        test_random_mix(52, 36, 580);
        test_random_mix(0, 0, 580);
        in_valid <= 1'b0;
        while (expected_views_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d instructions with %0d branches taken; %0d results checked",
                 instr_count, branches_taken, results_checked);
        $display("covered directed extremes, random mixes under idling and a long output stall");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
